/* hdl/rc_channel_frame_builder_assert.svh */
// ----------------------------------------------------------------------------
// rc_channel_frame_builder_assert.svh
// Assertion macros used by rcfb_packer. The macros expect
// clk and rst_n to be in scope where they are used.
// ----------------------------------------------------------------------------
`ifndef RC_CHANNEL_FRAME_BUILDER_ASSERT_SVH
`define RC_CHANNEL_FRAME_BUILDER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define RCFB_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
// Next-cycle implication.
`define RCFB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define RCFB_ASSERT(lbl, ante, cons)
`define RCFB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hdl/rcfb_pkg.sv */
// ----------------------------------------------------------------------------
// rcfb_pkg
// Shared constants, types and the CRC-8 byte update for the frame builder.
// ----------------------------------------------------------------------------
package rcfb_pkg;

    localparam int unsigned CHAN_W = 11;

    // Header bytes.
    localparam logic [7:0] HDR_DEST = 8'hEE;
    localparam logic [7:0] HDR_LEN  = 8'd24;
    localparam logic [7:0] HDR_TYPE = 8'h16;

    // CRC-8 generator, MSB first, zero initial value.
    localparam logic [7:0] CRC_POLY = 8'hD5;

    // Channel index of the last channel in a frame.
    localparam logic [3:0] LAST_CHAN = 4'd15;

    // One output item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } rcfb_beat_t;

    // Handshake status from the packer to the top level.
    typedef struct packed {
        logic emit;
        logic item_done;
    } rcfb_pk_stat_t;

    // Fold one byte into the CRC, one bit per loop step.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

/* hdl/rcfb_in_if.sv */
// ----------------------------------------------------------------------------
// rcfb_in_if
// Channel value stream with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rcfb_in_if;
    logic                         valid;
    logic                         ready;
    logic [rcfb_pkg::CHAN_W-1:0]  channel_value;

    modport source (output valid, output channel_value, input ready);
    modport sink   (input valid, input channel_value, output ready);
endinterface

/* hdl/rcfb_out_if.sv */
// ----------------------------------------------------------------------------
// rcfb_out_if
// Frame byte stream with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rcfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;

    modport source (output valid, output out_byte, output run_last, output frame_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input frame_end,
                    output ready);
endinterface

/* hdl/rc_channel_frame_builder.sv */
// ----------------------------------------------------------------------------
// rc_channel_frame_builder
// The first byte of an item passes through the input slot and the output
// register; its other bytes follow one per cycle unless the output stalls.
// Throughput: one output byte per cycle unless the output stalls; an item
// holds the input slot until the last of its bytes (1 to 4) is emitted.
// Reset (rst_n, asynchronous, active low) empties both stages and starts a
// new frame with its header.
// Packs sixteen 11-bit channels into a 26-byte frame with header and CRC-8.
// ----------------------------------------------------------------------------
module rc_channel_frame_builder (
    input  logic        clk,
    input  logic        rst_n,
    rcfb_in_if.sink     channel,
    rcfb_out_if.source  stream
);

    logic                         slot_valid_reg;
    logic [rcfb_pkg::CHAN_W-1:0]  slot_value_reg;
    logic                         out_valid_reg;
    rcfb_pkg::rcfb_beat_t         out_beat_reg;
    rcfb_pkg::rcfb_beat_t         pk_beat;
    rcfb_pkg::rcfb_pk_stat_t      pk_stat;
    logic                         out_space;
    logic                         in_fire;

    // The output register takes a byte when empty or being drained.
    assign out_space     = !out_valid_reg || stream.ready;
    assign channel.ready = !slot_valid_reg || pk_stat.item_done;
    assign in_fire       = channel.valid && channel.ready;

    // Input slot holding the item being packed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slot_valid_reg <= 1'b0;
        end else if (in_fire) begin
            slot_valid_reg <= 1'b1;
        end else if (pk_stat.item_done) begin
            slot_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            slot_value_reg <= channel.channel_value;
        end
    end

    rcfb_packer u_packer (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (slot_valid_reg),
        .channel_value (slot_value_reg),
        .out_space     (out_space),
        .beat          (pk_beat),
        .stat          (pk_stat)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (pk_stat.emit) begin
            out_valid_reg <= 1'b1;
        end else if (stream.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pk_stat.emit) begin
            out_beat_reg <= pk_beat;
        end
    end

    assign stream.valid     = out_valid_reg;
    assign stream.out_byte  = out_beat_reg.out_byte;
    assign stream.run_last  = out_beat_reg.run_last;
    assign stream.frame_end = out_beat_reg.frame_end;

endmodule

/* hdl/rcfb_packer.sv */
// ----------------------------------------------------------------------------
// rcfb_packer
// Holds the frame state and walks through the bytes caused by the held
// channel item, a byte per cycle unless stalled: header, payload, closing CRC.
// ----------------------------------------------------------------------------
`include "rc_channel_frame_builder_assert.svh"

module rcfb_packer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  logic [rcfb_pkg::CHAN_W-1:0]  channel_value,
    input  logic                         out_space,
    output rcfb_pkg::rcfb_beat_t         beat,
    output rcfb_pkg::rcfb_pk_stat_t      stat
);

    // Frame state.
    logic [3:0] ch_reg;
    logic [3:0] ch_next;
    logic [6:0] left_reg;
    logic [6:0] left_next;
    logic [2:0] lc_reg;
    logic [2:0] lc_next;
    logic [7:0] crc_reg;
    logic [7:0] crc_next;
    logic [1:0] step_reg;
    logic [1:0] step_next;

    logic [23:0] acc;
    logic        two_bytes;
    logic [2:0]  hdr_n;
    logic [2:0]  pay_n;
    logic [2:0]  last_step;
    logic [2:0]  step_w;
    logic [2:0]  pay_idx;
    logic        is_hdr;
    logic        is_pay;
    logic        is_crc;
    logic        is_last;
    logic        emit;
    logic        item_done;
    logic [7:0]  byte_val;
    logic [7:0]  hdr_byte;

    // Merge the new channel bits above the leftover bits.
    assign acc       = {17'd0, left_reg} | ({13'd0, channel_value} << lc_reg);
    assign two_bytes = (lc_reg >= 3'd5);
    assign hdr_n     = (ch_reg == 4'd0) ? 3'd3 : 3'd0;
    assign pay_n     = two_bytes ? 3'd2 : 3'd1;
    assign last_step = hdr_n + pay_n + {2'd0, (ch_reg == rcfb_pkg::LAST_CHAN)} - 3'd1;

    // Classify the current step.
    assign step_w  = {1'b0, step_reg};
    assign pay_idx = step_w - hdr_n;
    assign is_hdr  = (step_w < hdr_n);
    assign is_pay  = !is_hdr && (pay_idx < pay_n);
    assign is_crc  = !is_hdr && !is_pay;
    assign is_last = (step_w == last_step);

    assign emit      = item_valid && out_space;
    assign item_done = emit && is_last;

    // Header byte for the current step.
    always_comb
    begin
        unique case (step_reg)
            2'd0:    hdr_byte = rcfb_pkg::HDR_DEST;
            2'd1:    hdr_byte = rcfb_pkg::HDR_LEN;
            default: hdr_byte = rcfb_pkg::HDR_TYPE;
        endcase
    end

    // Output byte selection.
    always_comb
    begin
        if (is_hdr) begin
            byte_val = hdr_byte;
        end else if (is_pay) begin
            byte_val = pay_idx[0] ? acc[15:8] : acc[7:0];
        end else begin
            byte_val = crc_reg;
        end
    end

    assign beat.out_byte  = byte_val;
    assign beat.run_last  = is_last;
    assign beat.frame_end = is_crc;
    assign stat.emit      = emit;
    assign stat.item_done = item_done;

    // Next-state logic for the frame state and the step counter.
    always_comb
    begin
        ch_next   = ch_reg;
        left_next = left_reg;
        lc_next   = lc_reg;
        crc_next  = crc_reg;
        step_next = step_reg;
        if (emit) begin
            step_next = is_last ? 2'd0 : step_reg + 2'd1;
            if (is_hdr && step_reg == 2'd2) begin
                crc_next = rcfb_pkg::crc8_update(8'd0, rcfb_pkg::HDR_TYPE);
            end else if (is_pay) begin
                crc_next = rcfb_pkg::crc8_update(crc_reg, byte_val);
            end
        end
        if (item_done) begin
            if (ch_reg == rcfb_pkg::LAST_CHAN) begin
                ch_next   = 4'd0;
                left_next = 7'd0;
                lc_next   = 3'd0;
                crc_next  = 8'd0;
            end else begin
                ch_next   = ch_reg + 4'd1;
                left_next = two_bytes ? acc[22:16] : acc[14:8];
                lc_next   = two_bytes ? lc_reg - 3'd5 : lc_reg + 3'd3;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ch_reg   <= 4'd0;
            left_reg <= 7'd0;
            lc_reg   <= 3'd0;
            crc_reg  <= 8'd0;
            step_reg <= 2'd0;
        end else begin
            ch_reg   <= ch_next;
            left_reg <= left_next;
            lc_reg   <= lc_next;
            crc_reg  <= crc_next;
            step_reg <= step_next;
        end
    end

    // A frame always starts with no leftover payload bits.
    `RCFB_ASSERT(a_frame_start_empty, ch_reg == 4'd0, lc_reg == 3'd0 && left_reg == 7'd0)
    // The step counter never runs past the item's last byte.
    `RCFB_ASSERT(a_step_bound, item_valid, step_w <= last_step)
    // The closing CRC is only sent as the last byte of the last channel.
    `RCFB_ASSERT(a_crc_at_end, emit && is_crc, ch_reg == rcfb_pkg::LAST_CHAN && is_last)
    // Finishing the last channel clears the frame state.
    `RCFB_ASSERT_NEXT(a_wrap_clears, item_done && ch_reg == rcfb_pkg::LAST_CHAN,
                      ch_reg == 4'd0 && crc_reg == 8'd0 && step_reg == 2'd0)

endmodule

/* tb/sv/tb_rc_channel_frame_builder.sv */
// ----------------------------------------------------------------------------
// tb_rc_channel_frame_builder
// Self-checking bench for the channel frame builder. It sends channel values
// through the input stream in random bursts and predicts every frame byte:
// the header, the payload packed LSB-first, and the closing CRC-8. Each output
// byte is checked in order against the prediction while the output side stalls
// on its own changing pattern.
// ----------------------------------------------------------------------------
module tb_rc_channel_frame_builder;
    timeunit 1ns;
    timeprecision 1ps;

    // Predicts the frame bytes for each accepted channel and checks them.
    class frame_scoreboard;
        logic [3:0]            next_chan;
        logic [6:0]            spare_bits;
        logic [2:0]            spare_cnt;
        logic [7:0]            frame_crc;
        rcfb_pkg::rcfb_beat_t  bytes_due[$];
        int unsigned           errors;
        int unsigned           bytes_checked;
        int unsigned           frames_closed;

        function new();
            next_chan     = '0;
            spare_bits    = '0;
            spare_cnt     = '0;
            frame_crc     = '0;
            errors        = 0;
            bytes_checked = 0;
            frames_closed = 0;
        endfunction

        // CRC-8, MSB first, one data bit at a time.
        function logic [7:0] crc_fold(logic [7:0] crc, logic [7:0] data);
            logic [7:0] r;
            r = crc;
            for (int i = 7; i >= 0; i--) begin
                if (r[7] ^ data[i])
                    r = {r[6:0], 1'b0} ^ rcfb_pkg::CRC_POLY;
                else
                    r = {r[6:0], 1'b0};
            end
            return r;
        endfunction

        // Works out the bytes that one channel value releases.
        function void add_channel(logic [rcfb_pkg::CHAN_W-1:0] value);
            rcfb_pkg::rcfb_beat_t run[$];
            rcfb_pkg::rcfb_beat_t b;
            logic [17:0] acc;
            int          nbits;

            b.run_last  = 1'b0;
            b.frame_end = 1'b0;

            // A new frame opens with its three header bytes.
            if (next_chan == '0) begin
                b.out_byte = rcfb_pkg::HDR_DEST;
                run.push_back(b);
                b.out_byte = rcfb_pkg::HDR_LEN;
                run.push_back(b);
                b.out_byte = rcfb_pkg::HDR_TYPE;
                run.push_back(b);
                frame_crc  = crc_fold('0, rcfb_pkg::HDR_TYPE);
                spare_bits = '0;
                spare_cnt  = '0;
            end

            // Append the channel behind the bits still held and emit full bytes.
            acc   = 18'(spare_bits) | (18'(value) << spare_cnt);
            nbits = int'(spare_cnt) + rcfb_pkg::CHAN_W;
            while (nbits >= 8) begin
                b.out_byte = acc[7:0];
                run.push_back(b);
                frame_crc = crc_fold(frame_crc, acc[7:0]);
                acc       = acc >> 8;
                nbits     = nbits - 8;
            end
            spare_bits = acc[6:0];
            spare_cnt  = nbits[2:0];

            // The last channel closes the frame with the CRC.
            if (next_chan == rcfb_pkg::LAST_CHAN) begin
                b.out_byte  = frame_crc;
                b.frame_end = 1'b1;
                run.push_back(b);
                next_chan  = '0;
                spare_bits = '0;
                spare_cnt  = '0;
                frame_crc  = '0;
            end else begin
                next_chan = next_chan + 4'd1;
            end

            run[run.size() - 1].run_last = 1'b1;
            foreach (run[i])
                bytes_due.push_back(run[i]);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        // Compares one accepted output byte with the oldest prediction.
        task check_byte(rcfb_pkg::rcfb_beat_t got);
            rcfb_pkg::rcfb_beat_t want;
            if (bytes_due.size() == 0) begin
                report($sformatf("byte 0x%02h arrived with nothing due", got.out_byte));
            end else begin
                want = bytes_due.pop_front();
                bytes_checked++;
                if (got.out_byte !== want.out_byte)
                    report($sformatf("out_byte 0x%02h, predicted 0x%02h",
                                     got.out_byte, want.out_byte));
                if (got.run_last !== want.run_last)
                    report($sformatf("run_last %b, predicted %b on byte 0x%02h",
                                     got.run_last, want.run_last, want.out_byte));
                if (got.frame_end !== want.frame_end)
                    report($sformatf("frame_end %b, predicted %b on byte 0x%02h",
                                     got.frame_end, want.frame_end, want.out_byte));
                if (want.frame_end)
                    frames_closed++;
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    rcfb_in_if  ch_if ();
    rcfb_out_if st_if ();

    rc_channel_frame_builder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .channel (ch_if),
        .stream  (st_if)
    );

    frame_scoreboard sb;
    int unsigned     items_sent;
    int unsigned     burst_left;
    int unsigned     stall_cycle;
    int unsigned     stall_mode;

    // Clock generation.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Run time guard.
    initial
    begin
        #2_000_000;
        $display("Run timed out with %0d bytes still due.", sb.bytes_due.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Output side: check each accepted byte, then pick the next ready value.
    always @(posedge clk)
    begin
        if (rst_n && st_if.valid && st_if.ready)
            sb.check_byte('{out_byte: st_if.out_byte, run_last: st_if.run_last,
                            frame_end: st_if.frame_end});
        if (stall_cycle % 48 == 0)
            stall_mode = $urandom_range(0, 3);
        stall_cycle++;
        case (stall_mode)
            0:       st_if.ready <= 1'b1;
            1:       st_if.ready <= 1'($urandom_range(0, 1));
            2:       st_if.ready <= (stall_cycle % 3 == 0);
            default: st_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Sends one channel value, opening a new burst after a random gap.
    task automatic send_channel(input logic [rcfb_pkg::CHAN_W-1:0] value);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                ch_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        ch_if.valid         <= 1'b1;
        ch_if.channel_value <= value;
        do @(posedge clk); while (!ch_if.ready);
        sb.add_channel(value);
        items_sent++;
    endtask

    // Random channel value, leaning on extremes and single-bit patterns.
    function automatic logic [rcfb_pkg::CHAN_W-1:0] pick_channel();
        logic [rcfb_pkg::CHAN_W-1:0] one_hot;
        one_hot = rcfb_pkg::CHAN_W'(1) << $urandom_range(0, rcfb_pkg::CHAN_W - 1);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return rcfb_pkg::CHAN_W'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [rcfb_pkg::CHAN_W-1:0] directed[$];

        sb          = new();
        items_sent  = 0;
        burst_left  = 0;
        stall_cycle = 0;
        stall_mode  = 0;

        rst_n               = 1'b0;
        ch_if.valid         = 1'b0;
        ch_if.channel_value = '0;
        st_if.ready         = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One full frame of extremes and alternating patterns, then the
        // start of the next frame to see the header follow the CRC.
        directed = '{11'h000, 11'h7FF, 11'h000, 11'h7FF, 11'h555, 11'h2AA,
                     11'h001, 11'h400, 11'h3FF, 11'h7FE, 11'h7FF, 11'h7FF,
                     11'h000, 11'h000, 11'h123, 11'h6DC,
                     11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF};
        foreach (directed[i])
            send_channel(directed[i]);

        // Random part: finish the open frame, then full frames of random values.
        repeat (348)
            send_channel(pick_channel());

        // Drop valid at the edge that took the last item so it is not taken twice.
        ch_if.valid <= 1'b0;

        while (sb.bytes_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d channel items; checked %0d frame bytes in %0d closed frames.",
                 items_sent, sb.bytes_checked, sb.frames_closed);
        $display("Bursty input with varied output stalls; %0d mismatches.", sb.errors);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
